>>> src/tdps_pkg.sv
// ----------------------------------------------------------------------------
// tdps_pkg
// widths, setup word type and saturation helper for the depth plane setup
// ----------------------------------------------------------------------------
package tdps_pkg;

    localparam int XY_W   = 16;
    localparam int Z_W    = 24;
    localparam int OUT_W  = 48;
    localparam int DXY_W  = XY_W + 1;
    localparam int DZ_W   = Z_W + 1;
    localparam int PIJ_W  = DXY_W + DZ_W;
    localparam int PK_W   = 2 * DXY_W;
    localparam int N_W    = PIJ_W + 1;
    localparam int K_W    = PK_W + 1;
    localparam int CP_W   = XY_W + N_W;
    localparam int CNUM_W = CP_W + 2;
    localparam int QUOT_W = OUT_W + 1;

    typedef struct packed {
        logic signed [CNUM_W-1:0] cnum;
        logic signed [N_W-1:0]    ni;
        logic signed [N_W-1:0]    nj;
        logic signed [K_W-1:0]    nk;
    } setup_t;

    function automatic logic [OUT_W-1:0] sat48(input logic [QUOT_W-1:0] q,
                                               input logic ovf,
                                               input logic neg);
        logic [OUT_W-1:0] res;
        if (neg)
        begin
            if (ovf || q[QUOT_W-1] || (q[OUT_W-1] && (|q[OUT_W-2:0])))
                res = {1'b1, {(OUT_W-1){1'b0}}};
            else
                res = -q[OUT_W-1:0];
        end
        else
        begin
            if (ovf || q[QUOT_W-1] || q[OUT_W-1])
                res = {1'b0, {(OUT_W-1){1'b1}}};
            else
                res = q[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> src/tdps_if.sv
// ----------------------------------------------------------------------------
// tdps_if
// triangle input and plane output channels
// ----------------------------------------------------------------------------
interface tdps_tri_if;
    import tdps_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [XY_W-1:0]  v0_x;
    logic signed [XY_W-1:0]  v0_y;
    logic signed [Z_W-1:0]   v0_z;
    logic signed [XY_W-1:0]  v1_x;
    logic signed [XY_W-1:0]  v1_y;
    logic signed [Z_W-1:0]   v1_z;
    logic signed [XY_W-1:0]  v2_x;
    logic signed [XY_W-1:0]  v2_y;
    logic signed [Z_W-1:0]   v2_z;

    modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                    v2_x, v2_y, v2_z, input ready);
    modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                  v2_x, v2_y, v2_z, output ready);
endinterface

interface tdps_plane_if;
    import tdps_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] plane_offset;
    logic signed [OUT_W-1:0] slope_x;
    logic signed [OUT_W-1:0] slope_y;
    logic                    degenerate;

    modport source (output valid, plane_offset, slope_x, slope_y, degenerate,
                    input ready);
    modport sink (input valid, plane_offset, slope_x, slope_y, degenerate,
                  output ready);
endinterface

>>> src/tdps_front.sv
// ----------------------------------------------------------------------------
// tdps_front
// four-stage pipeline: edge vectors, cross product and plane offset numerator
// ----------------------------------------------------------------------------
module tdps_front
    import tdps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tdps_tri_if.sink    tri_in,
    output logic        push,
    input  logic        full,
    output setup_t      push_word
);

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [DXY_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [DZ_W-1:0]  az_reg, bz_reg;
    logic signed [XY_W-1:0]  x0_1_reg, y0_1_reg, x0_2_reg, y0_2_reg, x0_3_reg, y0_3_reg;
    logic signed [Z_W-1:0]   z0_1_reg, z0_2_reg, z0_3_reg;

    logic signed [PIJ_W-1:0] p_aybz_reg, p_azby_reg, p_azbx_reg, p_axbz_reg;
    logic signed [PK_W-1:0]  p_axby_reg, p_aybx_reg;

    logic signed [N_W-1:0]   ni_3_reg, nj_3_reg, ni_4_reg, nj_4_reg;
    logic signed [K_W-1:0]   nk_3_reg, nk_4_reg;

    logic signed [CP_W-1:0]  cx_reg, cy_reg, cz_reg;

    assign en           = !v4_reg || !full;
    assign tri_in.ready = en;
    assign push         = v4_reg && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= tri_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg   <= DXY_W'(tri_in.v1_x) - DXY_W'(tri_in.v0_x);
            ay_reg   <= DXY_W'(tri_in.v1_y) - DXY_W'(tri_in.v0_y);
            az_reg   <= DZ_W'(tri_in.v1_z) - DZ_W'(tri_in.v0_z);
            bx_reg   <= DXY_W'(tri_in.v2_x) - DXY_W'(tri_in.v0_x);
            by_reg   <= DXY_W'(tri_in.v2_y) - DXY_W'(tri_in.v0_y);
            bz_reg   <= DZ_W'(tri_in.v2_z) - DZ_W'(tri_in.v0_z);
            x0_1_reg <= tri_in.v0_x;
            y0_1_reg <= tri_in.v0_y;
            z0_1_reg <= tri_in.v0_z;

            p_aybz_reg <= PIJ_W'(ay_reg) * PIJ_W'(bz_reg);
            p_azby_reg <= PIJ_W'(az_reg) * PIJ_W'(by_reg);
            p_azbx_reg <= PIJ_W'(az_reg) * PIJ_W'(bx_reg);
            p_axbz_reg <= PIJ_W'(ax_reg) * PIJ_W'(bz_reg);
            p_axby_reg <= PK_W'(ax_reg) * PK_W'(by_reg);
            p_aybx_reg <= PK_W'(ay_reg) * PK_W'(bx_reg);
            x0_2_reg   <= x0_1_reg;
            y0_2_reg   <= y0_1_reg;
            z0_2_reg   <= z0_1_reg;

            ni_3_reg <= N_W'(p_aybz_reg) - N_W'(p_azby_reg);
            nj_3_reg <= N_W'(p_azbx_reg) - N_W'(p_axbz_reg);
            nk_3_reg <= K_W'(p_axby_reg) - K_W'(p_aybx_reg);
            x0_3_reg <= x0_2_reg;
            y0_3_reg <= y0_2_reg;
            z0_3_reg <= z0_2_reg;

            cx_reg   <= CP_W'(x0_3_reg) * CP_W'(ni_3_reg);
            cy_reg   <= CP_W'(y0_3_reg) * CP_W'(nj_3_reg);
            cz_reg   <= CP_W'(z0_3_reg) * CP_W'(nk_3_reg);
            ni_4_reg <= ni_3_reg;
            nj_4_reg <= nj_3_reg;
            nk_4_reg <= nk_3_reg;
        end
    end

    always_comb
    begin
        push_word.cnum = CNUM_W'(cx_reg) + CNUM_W'(cy_reg) + CNUM_W'(cz_reg);
        push_word.ni   = ni_4_reg;
        push_word.nj   = nj_4_reg;
        push_word.nk   = nk_4_reg;
    end

endmodule

>>> src/tdps_fifo.sv
// ----------------------------------------------------------------------------
// tdps_fifo
// two-entry queue of setup words between front and back
// ----------------------------------------------------------------------------
module tdps_fifo
    import tdps_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  setup_t push_word,
    output logic   full,
    input  logic   pop,
    output logic   avail,
    output setup_t pop_word
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    setup_t          mem_reg [DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [AW:0]     cnt_reg;

    assign full     = cnt_reg == (AW+1)'(DEPTH);
    assign avail    = cnt_reg != '0;
    assign pop_word = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_word;
    end

endmodule

>>> src/tdps_div.sv
// ----------------------------------------------------------------------------
// tdps_div
// restoring divider, one quotient bit per cycle while run is high, with overflow flag
// ----------------------------------------------------------------------------
module tdps_div #(
    parameter int DW = 77,
    parameter int KW = 35,
    parameter int QW = 49
) (
    input  logic          clk,
    input  logic          start,
    input  logic          run,
    input  logic [DW-1:0] dividend,
    input  logic [KW-1:0] divisor,
    output logic [QW-1:0] quot,
    output logic          ovf
);

    localparam int UW = DW - QW;

    logic [KW-1:0]    rem_reg, div_reg;
    logic [QW-1:0]    low_reg, q_reg;
    logic             ovf_reg;
    logic [UW+KW-1:0] upper_ext, div_ext;
    logic [KW:0]      trial;

    assign upper_ext = {{KW{1'b0}}, dividend[DW-1:QW]};
    assign div_ext   = {{UW{1'b0}}, divisor};
    assign trial     = {rem_reg, low_reg[QW-1]};
    assign quot      = q_reg;
    assign ovf       = ovf_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= upper_ext[KW-1:0];
            div_reg <= divisor;
            low_reg <= dividend[QW-1:0];
            q_reg   <= '0;
            ovf_reg <= upper_ext >= div_ext;
        end
        else if (run)
        begin
            low_reg <= {low_reg[QW-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_reg <= KW'(trial - {1'b0, div_reg});
                q_reg   <= {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[KW-1:0];
                q_reg   <= {q_reg[QW-2:0], 1'b0};
            end
        end
    end

endmodule

>>> src/tdps_back.sv
// ----------------------------------------------------------------------------
// tdps_back
// three parallel dividers by k, sign and saturation, output register
// ----------------------------------------------------------------------------
module tdps_back
    import tdps_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         avail,
    input  setup_t       pop_word,
    output logic         pop,
    tdps_plane_if.source plane_out
);

    localparam int C_UP = (OUT_FRAC_BITS >= 16) ? OUT_FRAC_BITS - 16 : 0;
    localparam int C_DN = (OUT_FRAC_BITS < 16) ? 16 - OUT_FRAC_BITS : 0;
    localparam int S_UP = (OUT_FRAC_BITS >= 12) ? OUT_FRAC_BITS - 12 : 0;
    localparam int S_DN = (OUT_FRAC_BITS < 12) ? 12 - OUT_FRAC_BITS : 0;
    localparam int DW_C = CNUM_W + 16;
    localparam int DW_S = N_W + 20;
    localparam int CW   = $clog2(QUOT_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg;
    logic          neg_c_reg, neg_x_reg, neg_y_reg, deg_reg;
    logic          out_valid_reg;
    logic [OUT_W-1:0] off_reg, sx_reg, sy_reg;
    logic          out_deg_reg;
    logic          run, load;

    logic [CNUM_W-1:0] cmag;
    logic [N_W-1:0]    imag, jmag;
    logic [K_W-1:0]    kmag;
    logic [DW_C-1:0]   num_c;
    logic [DW_S-1:0]   num_x, num_y;
    logic [QUOT_W-1:0] q_c, q_x, q_y;
    logic              ovf_c, ovf_x, ovf_y;

    assign cmag  = pop_word.cnum[CNUM_W-1] ? -pop_word.cnum : pop_word.cnum;
    assign imag  = pop_word.ni[N_W-1] ? -pop_word.ni : pop_word.ni;
    assign jmag  = pop_word.nj[N_W-1] ? -pop_word.nj : pop_word.nj;
    assign kmag  = pop_word.nk[K_W-1] ? -pop_word.nk : pop_word.nk;
    assign num_c = (DW_C'(cmag) << C_UP) >> C_DN;
    assign num_x = (DW_S'(imag) << S_UP) >> S_DN;
    assign num_y = (DW_S'(jmag) << S_UP) >> S_DN;

    assign pop  = avail && (state_reg == ST_IDLE);
    assign run  = state_reg == ST_RUN;
    assign load = (state_reg == ST_HOLD) && (!out_valid_reg || plane_out.ready);

    tdps_div #(.DW(DW_C), .KW(K_W), .QW(QUOT_W)) u_div_c (
        .clk(clk), .start(pop), .run(run), .dividend(num_c), .divisor(kmag),
        .quot(q_c), .ovf(ovf_c)
    );

    tdps_div #(.DW(DW_S), .KW(K_W), .QW(QUOT_W)) u_div_x (
        .clk(clk), .start(pop), .run(run), .dividend(num_x), .divisor(kmag),
        .quot(q_x), .ovf(ovf_x)
    );

    tdps_div #(.DW(DW_S), .KW(K_W), .QW(QUOT_W)) u_div_y (
        .clk(clk), .start(pop), .run(run), .dividend(num_y), .divisor(kmag),
        .quot(q_y), .ovf(ovf_y)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (cnt_reg == CW'(QUOT_W - 1))
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (run)
                cnt_reg <= cnt_reg + 1'b1;
            else
                cnt_reg <= '0;
            if (load)
                out_valid_reg <= 1'b1;
            else if (plane_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            neg_c_reg <= pop_word.cnum[CNUM_W-1] != pop_word.nk[K_W-1];
            neg_x_reg <= pop_word.ni[N_W-1] == pop_word.nk[K_W-1];
            neg_y_reg <= pop_word.nj[N_W-1] == pop_word.nk[K_W-1];
            deg_reg   <= pop_word.nk == '0;
        end
        if (load)
        begin
            out_deg_reg <= deg_reg;
            if (deg_reg)
            begin
                off_reg <= '0;
                sx_reg  <= '0;
                sy_reg  <= '0;
            end
            else
            begin
                off_reg <= sat48(q_c, ovf_c, neg_c_reg);
                sx_reg  <= sat48(q_x, ovf_x, neg_x_reg);
                sy_reg  <= sat48(q_y, ovf_y, neg_y_reg);
            end
        end
    end

    assign plane_out.valid        = out_valid_reg;
    assign plane_out.plane_offset = off_reg;
    assign plane_out.slope_x      = sx_reg;
    assign plane_out.slope_y      = sy_reg;
    assign plane_out.degenerate   = out_deg_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> cnt_reg <= CW'(QUOT_W - 1))
        else $error("divider step count out of range");

    a_rose_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_HOLD))
        else $error("output word loaded outside hold");

    a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HOLD && $past(state_reg == ST_HOLD) |-> $stable(q_c) && $stable(q_x))
        else $error("quotient moved while held");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_deg_reg |-> off_reg == '0 && sx_reg == '0 && sy_reg == '0)
        else $error("degenerate word with nonzero plane");

endmodule

>>> src/triangle_depth_plane_setup.sv
// ----------------------------------------------------------------------------
// triangle_depth_plane_setup
// depth plane equation from three screen-space vertices
// ----------------------------------------------------------------------------
// A four-stage front pipeline forms the cross product of the edge vectors and
// the offset numerator and takes a new triangle every cycle until its
// two-entry queue is full. The back end divides by k with three bit-serial
// dividers in parallel, one quotient bit per cycle, and pops the next setup
// word from the queue only once the current plane word has been loaded into
// the output register.
module triangle_depth_plane_setup
    import tdps_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    tdps_tri_if.sink     tri_in,
    tdps_plane_if.source plane_out
);

    logic   push, full, pop, avail;
    setup_t push_word, pop_word;

    tdps_front u_front (
        .clk(clk), .rst_n(rst_n), .tri_in(tri_in),
        .push(push), .full(full), .push_word(push_word)
    );

    tdps_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .push(push), .push_word(push_word),
        .full(full), .pop(pop), .avail(avail), .pop_word(pop_word)
    );

    tdps_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .avail(avail), .pop_word(pop_word),
        .pop(pop), .plane_out(plane_out)
    );

endmodule

>>> test/triangle_depth_plane_setup_tb.sv
// ----------------------------------------------------------------------------
// triangle_depth_plane_setup_tb
// drives triangles through the depth plane setup with random bursts and
// output stalls, and checks every plane word against an exact integer model
// ----------------------------------------------------------------------------
module triangle_depth_plane_setup_tb;
    import tdps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC        = 24;
    localparam int N_RANDOM    = 1200;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [XY_W-1:0] x0, y0, x1, y1, x2, y2;
        logic signed [Z_W-1:0]  z0, z1, z2;
    } tri_t;

    typedef struct {
        logic signed [OUT_W-1:0] offset, sx, sy;
        logic                    degen;
    } plane_t;

    typedef struct {
        tri_t   t;
        logic   known;
        plane_t p;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cycles = 0;
    int   errors = 0;
    bit   feeding_done = 1'b0;
    bit   long_hold = 1'b0;

    plane_t expected_planes[$];
    row_t   rows[$];

    tdps_tri_if   tri_in();
    tdps_plane_if plane_out();

    triangle_depth_plane_setup #(.OUT_FRAC_BITS(FRAC)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .tri_in    (tri_in.sink),
        .plane_out (plane_out.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // floor(num * 2^sh / den) with the cap at 2^48
    function automatic logic [127:0] scaled_div(logic [127:0] num, int sh,
                                                logic [127:0] den);
        logic [127:0] q;
        if (sh < 0)
            q = num / (den << -sh);
        else
            q = (num << sh) / den;
        if (q > (128'd1 << 48))
            q = 128'd1 << 48;
        return q;
    endfunction

    function automatic logic [OUT_W-1:0] clamp48(logic [127:0] m, logic neg);
        logic [127:0] lim;
        if (neg)
        begin
            lim = 128'd1 << 47;
            if (m > lim)
                m = lim;
            return -m[OUT_W-1:0];
        end
        lim = (128'd1 << 47) - 1;
        if (m > lim)
            m = lim;
        return m[OUT_W-1:0];
    endfunction

    function automatic plane_t depth_plane(tri_t t);
        longint ax, ay, az, bx, by, bz, ni, nj, nk, cn;
        logic [127:0] km, cm, im, jm;
        plane_t p;
        ax = longint'(t.x1) - t.x0;
        ay = longint'(t.y1) - t.y0;
        az = longint'(t.z1) - t.z0;
        bx = longint'(t.x2) - t.x0;
        by = longint'(t.y2) - t.y0;
        bz = longint'(t.z2) - t.z0;
        ni = ay * bz - az * by;
        nj = az * bx - ax * bz;
        nk = ax * by - ay * bx;
        p = '{default: '0};
        if (nk == 0)
        begin
            p.degen = 1'b1;
            return p;
        end
        cn = longint'(t.x0) * ni + longint'(t.y0) * nj + longint'(t.z0) * nk;
        km = nk < 0 ? -nk : nk;
        cm = cn < 0 ? -cn : cn;
        im = ni < 0 ? -ni : ni;
        jm = nj < 0 ? -nj : nj;
        p.offset = clamp48(scaled_div(cm, FRAC - 16, km), (cn < 0) != (nk < 0));
        p.sx = clamp48(scaled_div(im, FRAC - 12, km), ni != 0 && (ni < 0) == (nk < 0));
        p.sy = clamp48(scaled_div(jm, FRAC - 12, km), nj != 0 && (nj < 0) == (nk < 0));
        return p;
    endfunction

    function automatic tri_t random_tri();
        tri_t t;
        int   mode;
        mode = $urandom_range(0, 9);
        t.x0 = XY_W'($urandom); t.y0 = XY_W'($urandom); t.x1 = XY_W'($urandom);
        t.y1 = XY_W'($urandom); t.x2 = XY_W'($urandom); t.y2 = XY_W'($urandom);
        t.z0 = Z_W'($urandom); t.z1 = Z_W'($urandom); t.z2 = Z_W'($urandom);
        if (mode < 4)
        begin
            // small nearby triangles, the common case
            t.x1 = t.x0 + $signed(12'($urandom));
            t.y1 = t.y0 + $signed(12'($urandom));
            t.x2 = t.x0 + $signed(12'($urandom));
            t.y2 = t.y0 + $signed(12'($urandom));
        end
        else if (mode == 4)
        begin
            // collinear
            t.x2 = t.x1;
            t.y2 = t.y1;
        end
        else if (mode == 5)
        begin
            // tiny area, large slopes
            t.x1 = XY_W'(t.x0 + 1);
            t.y1 = t.y0;
            t.x2 = t.x0 + $signed(3'($urandom));
            t.y2 = XY_W'(t.y0 + 1);
        end
        return t;
    endfunction

    function automatic tri_t make_tri(int x0, int y0, int z0, int x1, int y1,
                                      int z1, int x2, int y2, int z2);
        tri_t t;
        t.x0 = XY_W'(x0); t.y0 = XY_W'(y0); t.z0 = Z_W'(z0);
        t.x1 = XY_W'(x1); t.y1 = XY_W'(y1); t.z1 = Z_W'(z1);
        t.x2 = XY_W'(x2); t.y2 = XY_W'(y2); t.z2 = Z_W'(z2);
        return t;
    endfunction

    task automatic add_row(tri_t t, logic known, plane_t p);
        row_t r;
        r.t = t;
        r.known = known;
        r.p = p;
        rows.push_back(r);
    endtask

    task automatic build_table();
        plane_t zero_degen, flat;
        zero_degen = '{offset: '0, sx: '0, sy: '0, degen: 1'b1};
        // flat plane at depth 1.0: offset 1<<24, zero slopes
        flat = '{offset: 48'sd16777216, sx: '0, sy: '0, degen: 1'b0};
        add_row(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, zero_degen);
        add_row(make_tri(16, 16, 5, 16, 16, 7, 100, 3, -9), 1'b1, zero_degen);
        add_row(make_tri(0, 0, 0, 16, 32, 1, 32, 64, 2), 1'b1, zero_degen);
        add_row(make_tri(0, 0, 65536, 16, 0, 65536, 0, 16, 65536), 1'b1, flat);
        add_row(make_tri(0, 0, 65536, 0, 16, 65536, 16, 0, 65536), 1'b1, flat);
        add_row(make_tri(-32768, -32768, -8388608, 32767, -32768, 8388607,
                         -32768, 32767, 8388607), 1'b0, zero_degen);
        add_row(make_tri(32767, 32767, 8388607, -32768, 32767, -8388608,
                         32767, -32768, -8388608), 1'b0, zero_degen);
        add_row(make_tri(0, 0, -8388608, 1, 0, 8388607, 0, 1, 8388607),
                1'b0, zero_degen);
        add_row(make_tri(0, 0, 8388607, 1, 0, -8388608, 0, 1, -8388608),
                1'b0, zero_degen);
        add_row(make_tri(32767, -32768, 8388607, 32766, -32768, 0,
                         32767, -32767, -8388608), 1'b0, zero_degen);
        add_row(make_tri(-1, -1, -1, 0, -1, 0, -1, 0, 0), 1'b0, zero_degen);
        add_row(make_tri(3, 5, 7, 10, 2, -3, -6, 9, 11), 1'b0, zero_degen);
        add_row(make_tri(-32768, 0, 1, 32767, 0, 2, 0, 1, -1), 1'b0, zero_degen);
        add_row(make_tri(0, -32768, 12345, 1, 32767, -54321, -1, 0, 0),
                1'b0, zero_degen);
        add_row(make_tri(21845, -21846, 4660, -21846, 21845, -4661, 1, 2, 3),
                1'b0, zero_degen);
    endtask

    task automatic send_tri(tri_t t);
        tri_in.valid <= 1'b1;
        tri_in.v0_x <= t.x0; tri_in.v0_y <= t.y0; tri_in.v0_z <= t.z0;
        tri_in.v1_x <= t.x1; tri_in.v1_y <= t.y1; tri_in.v1_z <= t.z1;
        tri_in.v2_x <= t.x2; tri_in.v2_y <= t.y2; tri_in.v2_z <= t.z2;
        do
            @(posedge clk);
        while (!tri_in.ready);
        expected_planes.push_back(depth_plane(t));
    endtask

    task automatic idle_gap();
        int gap;
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 60) : 0;
        if (gap > 0)
        begin
            tri_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        tri_t t;
        int   burst;
        tri_in.valid <= 1'b0;
        tri_in.v0_x <= '0; tri_in.v0_y <= '0; tri_in.v0_z <= '0;
        tri_in.v1_x <= '0; tri_in.v1_y <= '0; tri_in.v1_z <= '0;
        tri_in.v2_x <= '0; tri_in.v2_y <= '0; tri_in.v2_z <= '0;
        build_table();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[r])
        begin
            send_tri(rows[r].t);
            if (rows[r].known)
                expected_planes[$] = rows[r].p;
            idle_gap();
        end
        // let the output stall back up into the input
        long_hold = 1'b1;
        for (int n = 0; n < N_RANDOM; n += burst)
        begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst; b++)
            begin
                t = random_tri();
                send_tri(t);
            end
            idle_gap();
        end
        tri_in.valid <= 1'b0;
        feeding_done = 1'b1;
    end

    initial
    begin
        int hold;
        plane_out.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                plane_out.ready <= 1'b0;
                hold = 600;
                repeat (hold) @(posedge clk);
            end
            if (($urandom_range(0, 255) & 8'h30) == 8'h30 && cycles % 5000 < 3000)
                plane_out.ready <= $urandom_range(0, 2) != 0;
            else if (cycles % 5000 >= 3000)
                plane_out.ready <= 1'b1;
            else
                plane_out.ready <= 1'($urandom_range(0, 1));
        end
    end

    always @(posedge clk)
    begin
        plane_t e;
        cycles <= cycles + 1;
        if (rst_n && plane_out.valid && plane_out.ready)
        begin
            if (expected_planes.size() == 0)
            begin
                $error("plane word with no triangle pending");
                errors++;
            end
            else
            begin
                e = expected_planes.pop_front();
                if (plane_out.plane_offset !== e.offset)
                begin
                    $error("plane_offset expected %0d got %0d", e.offset,
                           plane_out.plane_offset);
                    errors++;
                end
                if (plane_out.slope_x !== e.sx)
                begin
                    $error("slope_x expected %0d got %0d", e.sx, plane_out.slope_x);
                    errors++;
                end
                if (plane_out.slope_y !== e.sy)
                begin
                    $error("slope_y expected %0d got %0d", e.sy, plane_out.slope_y);
                    errors++;
                end
                if (plane_out.degenerate !== e.degen)
                begin
                    $error("degenerate expected %0d got %0d", e.degen,
                           plane_out.degenerate);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        wait (feeding_done && expected_planes.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d words pending", cycles,
                 expected_planes.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
